@@ sv/nearest_palette_quantizer_assert.svh @@
// Assertion macros used by the quantizer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef NEAREST_PALETTE_QUANTIZER_ASSERT_SVH
`define NEAREST_PALETTE_QUANTIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/npq_pkg.sv @@
// Shared constants, types and the palette table of the nearest-palette quantizer.
// Depends on nothing; imported by the channel interfaces, the quantizer, the checker and the testbench.
package npq_pkg;

   localparam int PALETTE_SIZE    = 22;
   localparam int COUNT_WIDTH     = 32;
   localparam int IDX_WIDTH       = 5;
   localparam int MAX_ENTRIES     = 2 ** IDX_WIDTH;
   localparam int COLOR_WIDTH     = 24;
   localparam int DIST_WIDTH      = 18;
   localparam int HIST_ADDR_WIDTH = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   typedef logic [DIST_WIDTH-1:0]  dist_type;
   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [COLOR_WIDTH-1:0] color_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_UPDATE,
      S_SCAN,
      S_DRAIN,
      S_OUT
   } state_type;

   // Palette in 0xRRGGBB order; entries past the listed colors are black.
   function automatic color_type palette_rgb(input idx_type i);
      color_type c;
      case (i)
         5'd0:    c = 24'hFFFFFF;
         5'd1:    c = 24'hC1C1C1;
         5'd2:    c = 24'hEF130B;
         5'd3:    c = 24'hFF7100;
         5'd4:    c = 24'hFFE400;
         5'd5:    c = 24'h00CC00;
         5'd6:    c = 24'h00B2FF;
         5'd7:    c = 24'h231FD3;
         5'd8:    c = 24'hA300BA;
         5'd9:    c = 24'hD37CAA;
         5'd10:   c = 24'hA0522D;
         5'd11:   c = 24'h000000;
         5'd12:   c = 24'h4C4C4C;
         5'd13:   c = 24'h740B07;
         5'd14:   c = 24'hC23800;
         5'd15:   c = 24'hE8A200;
         5'd16:   c = 24'h005510;
         5'd17:   c = 24'h00569E;
         5'd18:   c = 24'h0E0865;
         5'd19:   c = 24'h550069;
         5'd20:   c = 24'hA75574;
         5'd21:   c = 24'h63300D;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

   // Squared difference of two color channels.
   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

endpackage

@@ sv/npq_if.sv @@
// Valid/ready channel interfaces for the quantizer's pixel input and result output.
// Depends on npq_pkg for field widths.
interface npq_req_if import npq_pkg::*; ();
   logic      valid;
   logic      ready;
   color_type pixel_color;
   logic      frame_last;

   modport source (output valid, output pixel_color, output frame_last, input ready);
   modport sink   (input valid, input pixel_color, input frame_last, output ready);
endinterface

interface npq_rsp_if import npq_pkg::*; ();
   logic    valid;
   logic    ready;
   idx_type palette_index;
   logic    dominant_valid;
   idx_type dominant_index;

   modport source (output valid, output palette_index, output dominant_valid,
                   output dominant_index, input ready);
   modport sink   (input valid, input palette_index, input dominant_valid,
                   input dominant_index, output ready);
endinterface

@@ sv/npq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module npq_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 22,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/nearest_palette_quantizer.sv @@
// Nearest-palette quantizer: maps each pixel (red in bits 7:0, blue in 23:16) to
// the closest of PALETTE_SIZE fixed colors by squared RGB distance, lowest index on
// a tie, and counts the choice in a saturating histogram held in a RAM. A pixel's
// result is loaded into the output register after the registered distance lanes,
// the min tree with histogram read and the read-modify-write of the count; the
// input reopens only after the load, so a new pixel is not accepted before the
// previous one is through. A pixel marked frame_last adds a sweep in which the
// histogram is read through its single read port to find the most frequent index
// (lowest index on a tie); all counts then clear at once through per-entry valid
// bits, which reset also clears. The result sits in an output register, so the
// next pixel is accepted while the previous result waits to be taken; a result
// that cannot be loaded holds the input closed.
// Depends on npq_pkg, npq_if, npq_ram and nearest_palette_quantizer_assert.svh.
`include "nearest_palette_quantizer_assert.svh"

module nearest_palette_quantizer import npq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   npq_req_if.sink   req_chan,
   npq_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;

   dist_type  dist_ff [MAX_ENTRIES];
   dist_type  dist_in [MAX_ENTRIES];
   logic      last_ff, last_in;
   idx_type   idx_ff, idx_in;
   logic      rd_valid_ff, rd_valid_in;
   idx_type   scan_cnt_ff, scan_cnt_in;
   logic      cmp_pend_ff, cmp_pend_in;
   idx_type   cmp_addr_ff, cmp_addr_in;
   count_type best_cnt_ff, best_cnt_in;
   idx_type   best_idx_ff, best_idx_in;
   logic [PALETTE_SIZE-1:0] hist_valid_ff, hist_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   idx_type   rsp_idx_ff, rsp_idx_in;
   logic      rsp_dval_ff, rsp_dval_in;
   idx_type   rsp_dom_ff, rsp_dom_in;

   logic      req_accept;
   logic      rsp_free;
   logic      rsp_load;
   idx_type   near_idx;
   count_type cur_count;

   logic                       ram_wr_en;
   logic [HIST_ADDR_WIDTH-1:0] ram_wr_addr;
   count_type                  ram_wr_data;
   logic                       ram_rd_en;
   logic [HIST_ADDR_WIDTH-1:0] ram_rd_addr;
   count_type                  ram_rd_data;

   dist_type lvl_d [IDX_WIDTH+1][MAX_ENTRIES];
   idx_type  lvl_i [IDX_WIDTH+1][MAX_ENTRIES];

   npq_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (PALETTE_SIZE)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load   = (state_ff == S_OUT) && rsp_free;
   // Entries not written since the last clear read as zero.
   assign cur_count  = rd_valid_ff ? ram_rd_data : '0;

   // One distance lane per palette entry; unused lanes never win.
   always_comb begin
      color_type c;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         c = palette_rgb(IDX_WIDTH'(i));
         if (i < PALETTE_SIZE) begin
            dist_in[i] = DIST_WIDTH'(sq_diff(req_chan.pixel_color[7:0], c[23:16]))
                       + DIST_WIDTH'(sq_diff(req_chan.pixel_color[15:8], c[15:8]))
                       + DIST_WIDTH'(sq_diff(req_chan.pixel_color[23:16], c[7:0]));
         end else begin
            dist_in[i] = '1;
         end
      end
   end

   // Pairwise min tree; the lower index keeps a tie.
   always_comb begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         lvl_d[0][k] = dist_ff[k];
         lvl_i[0][k] = IDX_WIDTH'(k);
      end
      for (int l = 1; l <= IDX_WIDTH; l++) begin
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (k < (MAX_ENTRIES >> l)) begin
               if (lvl_d[l-1][2*k+1] < lvl_d[l-1][2*k]) begin
                  lvl_d[l][k] = lvl_d[l-1][2*k+1];
                  lvl_i[l][k] = lvl_i[l-1][2*k+1];
               end else begin
                  lvl_d[l][k] = lvl_d[l-1][2*k];
                  lvl_i[l][k] = lvl_i[l-1][2*k];
               end
            end else begin
               lvl_d[l][k] = '1;
               lvl_i[l][k] = '0;
            end
         end
      end
      near_idx = lvl_i[IDX_WIDTH][0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_FIND;
            end
         end
         S_FIND:   state_in = S_UPDATE;
         S_UPDATE: state_in = last_ff ? S_SCAN : S_OUT;
         S_SCAN: begin
            if (scan_cnt_ff == IDX_WIDTH'(PALETTE_SIZE - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_OUT;
         S_OUT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs and RAM port drive.
   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = '0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff[HIST_ADDR_WIDTH-1:0];
      ram_wr_data    = (cur_count != '1) ? cur_count + 1'b1 : cur_count;
      case (state_ff)
         S_IDLE: req_chan.ready = 1'b1;
         S_FIND: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = near_idx[HIST_ADDR_WIDTH-1:0];
         end
         S_UPDATE: ram_wr_en = 1'b1;
         S_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_cnt_ff[HIST_ADDR_WIDTH-1:0];
         end
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      last_in       = req_accept ? req_chan.frame_last : last_ff;
      idx_in        = (state_ff == S_FIND) ? near_idx : idx_ff;
      rd_valid_in   = ram_rd_en ? hist_valid_ff[ram_rd_addr] : rd_valid_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_pend_in   = (state_ff == S_SCAN);
      cmp_addr_in   = scan_cnt_ff;
      best_cnt_in   = best_cnt_ff;
      best_idx_in   = best_idx_ff;
      hist_valid_in = hist_valid_ff;

      if (state_ff == S_UPDATE) begin
         hist_valid_in[idx_ff[HIST_ADDR_WIDTH-1:0]] = 1'b1;
         scan_cnt_in = '0;
         best_cnt_in = '0;
         best_idx_in = '0;
      end
      if (state_ff == S_SCAN) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      // Strictly greater keeps the lowest index on a tie.
      if (cmp_pend_ff && (cur_count > best_cnt_ff)) begin
         best_cnt_in = cur_count;
         best_idx_in = cmp_addr_ff;
      end
      if (state_ff == S_DRAIN) begin
         hist_valid_in = '0;
      end

      rsp_idx_in  = rsp_load ? idx_ff : rsp_idx_ff;
      rsp_dval_in = rsp_load ? last_ff : rsp_dval_ff;
      rsp_dom_in  = rsp_load ? (last_ff ? best_idx_ff : '0) : rsp_dom_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hist_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hist_valid_ff <= hist_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmp_pend_ff   <= cmp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dist_ff <= dist_in;
      end
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      rd_valid_ff <= rd_valid_in;
      scan_cnt_ff <= scan_cnt_in;
      cmp_addr_ff <= cmp_addr_in;
      best_cnt_ff <= best_cnt_in;
      best_idx_ff <= best_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_dval_ff <= rsp_dval_in;
      rsp_dom_ff  <= rsp_dom_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.palette_index  = rsp_idx_ff;
   assign rsp_chan.dominant_valid = rsp_dval_ff;
   assign rsp_chan.dominant_index = rsp_dom_ff;

   `NPQ_ASSERT_IMPLY(a_ram_no_collide, clock, reset, ram_wr_en && ram_rd_en,
      ram_wr_addr != ram_rd_addr, "histogram read and write hit the same entry")
   `NPQ_ASSERT_NEXT(a_accept_to_find, clock, reset, req_accept,
      state_ff == S_FIND, "accepted transaction did not enter the search")
   `NPQ_ASSERT_NEXT(a_drain_clears, clock, reset, state_ff == S_DRAIN,
      hist_valid_ff == '0, "histogram not cleared after frame scan")
   `NPQ_ASSERT_IMPLY(a_index_range, clock, reset, rsp_valid_ff,
      (rsp_idx_ff < IDX_WIDTH'(PALETTE_SIZE)) && (rsp_dom_ff < IDX_WIDTH'(PALETTE_SIZE)),
      "result index outside the palette")

endmodule

@@ tb/nearest_palette_quantizer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the nearest-palette quantizer: watches the pixel and result channels.
// Predicts index and dominant color per transaction and compares field by field.
// Depends on npq_pkg and the npq_if channel interfaces.
module nearest_palette_quantizer_checker import npq_pkg::*; (
   input  logic clock,
   input  logic reset,
   npq_req_if   req_mon,
   npq_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding
);

   typedef struct packed {
      idx_type palette_index;
      logic    dominant_valid;
      idx_type dominant_index;
   } quant_result_type;

   // Palette in 0xRRGGBB order
   localparam logic [23:0] PALETTE_RGB [PALETTE_SIZE] = '{
      24'hFFFFFF, 24'hC1C1C1, 24'hEF130B, 24'hFF7100, 24'hFFE400, 24'h00CC00,
      24'h00B2FF, 24'h231FD3, 24'hA300BA, 24'hD37CAA, 24'hA0522D, 24'h000000,
      24'h4C4C4C, 24'h740B07, 24'hC23800, 24'hE8A200, 24'h005510, 24'h00569E,
      24'h0E0865, 24'h550069, 24'hA75574, 24'h63300D
   };

   count_type        hist_count [PALETTE_SIZE];
   quant_result_type expected_results [$];

   // Pixel holds red in the low byte, palette holds red in the high byte
   function automatic idx_type nearest_entry(input color_type pix);
      int      min_sum;
      int      sq_sum;
      int      dr;
      int      dg;
      int      db;
      idx_type best;
      min_sum = 32'h7FFFFFFF;
      best = '0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         dr = int'(pix[7:0])   - int'(PALETTE_RGB[i][23:16]);
         dg = int'(pix[15:8])  - int'(PALETTE_RGB[i][15:8]);
         db = int'(pix[23:16]) - int'(PALETTE_RGB[i][7:0]);
         sq_sum = dr * dr + dg * dg + db * db;
         // strict compare keeps the lower index on a tie
         if (sq_sum < min_sum) begin
            min_sum = sq_sum;
            best = idx_type'(i);
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      quant_result_type want;
      quant_result_type got;
      idx_type          idx;
      idx_type          dom;
      count_type        most;
      bit               bad;
      if (reset) begin
         foreach (hist_count[i]) hist_count[i] = '0;
         mismatches = 0;
         outstanding = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            idx = nearest_entry(req_mon.pixel_color);
            if (hist_count[idx] != '1) hist_count[idx]++;
            dom = '0;
            if (req_mon.frame_last) begin
               most = '0;
               for (int i = 0; i < PALETTE_SIZE; i++) begin
                  if (hist_count[i] > most) begin
                     most = hist_count[i];
                     dom = idx_type'(i);
                  end
               end
               foreach (hist_count[i]) hist_count[i] = '0;
            end
            want = '{idx, req_mon.frame_last, dom};
            expected_results.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.palette_index, rsp_mon.dominant_valid, rsp_mon.dominant_index};
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: palette_index %0d", got.palette_index);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               bad = 1'b0;
               if (got.palette_index !== want.palette_index) begin
                  $error("palette_index: expected %0d, actual %0d",
                         want.palette_index, got.palette_index);
                  bad = 1'b1;
               end
               if (got.dominant_valid !== want.dominant_valid) begin
                  $error("dominant_valid: expected %0d, actual %0d",
                         want.dominant_valid, got.dominant_valid);
                  bad = 1'b1;
               end
               if (got.dominant_index !== want.dominant_index) begin
                  $error("dominant_index: expected %0d, actual %0d",
                         want.dominant_index, got.dominant_index);
                  bad = 1'b1;
               end
               if (bad) mismatches++;
            end
         end
         outstanding = expected_results.size();
      end
   end

endmodule

@@ tb/nearest_palette_quantizer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the nearest-palette quantizer: clock, reset, pixel and stall stimulus.
// Depends on npq_pkg, npq_if, the quantizer RTL and nearest_palette_quantizer_checker.
module nearest_palette_quantizer_tb import npq_pkg::*;;

   localparam int PIXEL_COUNT   = 400;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = PALETTE_SIZE + 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   outstanding;
   int   idle_cycles = 0;
   bit   burst_mode = 1'b0;

   npq_req_if req_chan ();
   npq_rsp_if rsp_chan ();

   nearest_palette_quantizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   nearest_palette_quantizer_checker quant_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort when neither channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Palette is 0xRRGGBB, pixel puts red in the low byte
   function automatic color_type to_pixel(input color_type rgb);
      return {rgb[7:0], rgb[15:8], rgb[23:16]};
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] chan);
      int v;
      v = int'(chan) + int'($urandom_range(0, 24)) - 12;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic color_type near_color(input idx_type i);
      color_type c;
      c = to_pixel(palette_rgb(i));
      if ($urandom_range(0, 3) == 0) return c;
      return {jitter(c[23:16]), jitter(c[15:8]), jitter(c[7:0])};
   endfunction

   function automatic color_type random_pixel();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return color_type'($urandom);
      if (pick < 65) return near_color(idx_type'($urandom_range(0, PALETTE_SIZE - 1)));
      // gray levels exactly halfway between two palette grays
      if (pick < 75) return ($urandom_range(0, 1) != 0) ? 24'h262626 : 24'hE0E0E0;
      return {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
              ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
              ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
   endfunction

   function automatic int pick_gap();
      int pick;
      if (burst_mode) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_pixel(input color_type pix, input logic last);
      req_chan.valid = 1'b1;
      req_chan.pixel_color = pix;
      req_chan.frame_last = last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_chan.valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Result side: random stalls, with long stretches of steady ready
   initial begin
      int pick;
      int run;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            rsp_chan.ready = 1'b1;
            run = $urandom_range(60, 150);
         end else if (pick < 70) begin
            rsp_chan.ready = 1'b1;
            run = $urandom_range(1, 12);
         end else if (pick < 95) begin
            rsp_chan.ready = 1'b0;
            run = $urandom_range(1, 3);
         end else begin
            rsp_chan.ready = 1'b0;
            run = $urandom_range(10, 40);
         end
         repeat (run) @(negedge clock);
      end
   end

   initial begin
      int        frame_len;
      int        pick;
      int        sent;
      int        frame_no;
      idx_type   fav;
      color_type pix;
      req_chan.valid = 1'b0;
      req_chan.pixel_color = '0;
      req_chan.frame_last = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // One frame of every exact palette color: all counts tie, lowest index wins
      for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
         send_pixel(to_pixel(palette_rgb(idx_type'(i))), i == 0);
         hold_off(pick_gap());
      end
      // Equidistant grays resolve to the lower index; two-pixel tie, then one-pixel frame
      send_pixel(24'hE0E0E0, 1'b0);
      send_pixel(24'h262626, 1'b1);
      send_pixel(24'h262626, 1'b1);
      drain_results();

      // Frames biased toward one color so the dominant index varies
      sent = 0;
      frame_no = 0;
      while (sent < PIXEL_COUNT) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) frame_len = 1;
         else if (pick < 8) frame_len = $urandom_range(2, 24);
         else frame_len = $urandom_range(40, 80);
         fav = idx_type'($urandom_range(0, PALETTE_SIZE - 1));
         burst_mode = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < frame_len; k++) begin
            pix = ($urandom_range(0, 1) != 0) ? near_color(fav) : random_pixel();
            send_pixel(pix, k == frame_len - 1);
            sent++;
            hold_off(pick_gap());
         end
         frame_no++;
         if (frame_no % 8 == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/npq_pkg.sv
sv/npq_if.sv
sv/npq_ram.sv
sv/nearest_palette_quantizer.sv
tb/nearest_palette_quantizer_checker.sv
tb/nearest_palette_quantizer_tb.sv
